>>> src/wsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    // ring depth, a power of two; counters carry one extra bit so full and empty differ
    localparam int unsigned DEPTH   = 1024;
    localparam int unsigned ADDR_W  = $clog2(DEPTH);
    localparam int unsigned CNT_W   = ADDR_W + 1;
    localparam int unsigned VALUE_W = 12;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned STAT_W  = 2;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TAKE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STEAL = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;   // input transfer: run the operation, capture the result
    } dp_cmd_t;

endpackage

`default_nettype wire

>>> src/work_stealing_deque_core.sv
`timescale 1ns / 1ps
`default_nettype none

// work-stealing deque of 12-bit task indices in a ring of wsd_pkg::DEPTH entries (1024).
// each input transfer carries one operation: push at the bottom, take from the bottom
// (lifo) or steal from the top (fifo); each produces exactly one result transfer with a
// status (success, empty, full) and the index taken or stolen, zero otherwise. a push on
// a full ring is dropped; taking the last element advances top instead of bottom. the
// result appears in the cycle after the input transfer and is held until taken; a new
// operation is accepted in the same cycle its predecessor's result is taken, so the
// block sustains one operation per cycle while out_ready stays high. that figure is set
// by the single-port ring ram, read or written once per operation with registered read
// data. the ring needs no clearing after reset: only entries pushed earlier are read.

module work_stealing_deque_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // operation channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [wsd_pkg::MODE_W-1:0]    mode,
    input  wire logic [wsd_pkg::VALUE_W-1:0]   value_in,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [wsd_pkg::STAT_W-1:0]    status,
    output logic      [wsd_pkg::VALUE_W-1:0]   value_out
);

    // controller issues one load per input transfer
    wsd_pkg::dp_cmd_t cmd;

    // handshake sequencing: idle, or holding a result
    wsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // ring ram, bottom/top counters and result register
    wsd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .mode      (mode),
        .value_in  (value_in),
        .status    (status),
        .value_out (value_out)
    );

endmodule

`default_nettype wire

>>> src/wsd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module wsd_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output wsd_pkg::dp_cmd_t     cmd
);

    wsd_pkg::state_t state_reg;
    wsd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wsd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd.load   = 1'b0;
        case (state_reg)
            wsd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = wsd_pkg::ST_RESULT;
                end
            end
            wsd_pkg::ST_RESULT:
            begin
                out_valid = 1'b1;
                // result leaving frees the result register for the next item
                in_ready  = out_ready;
                if (out_ready)
                begin
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = wsd_pkg::ST_RESULT;
                    end
                    else
                    begin
                        state_next = wsd_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = wsd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/wsd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module wsd_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire wsd_pkg::dp_cmd_t              cmd,
    input  wire logic [wsd_pkg::MODE_W-1:0]    mode,
    input  wire logic [wsd_pkg::VALUE_W-1:0]   value_in,
    output logic      [wsd_pkg::STAT_W-1:0]    status,
    output logic      [wsd_pkg::VALUE_W-1:0]   value_out
);

    logic [wsd_pkg::VALUE_W-1:0] ring_mem [wsd_pkg::DEPTH];

    logic [wsd_pkg::CNT_W-1:0]   bottom_reg;
    logic [wsd_pkg::CNT_W-1:0]   bottom_next;
    logic [wsd_pkg::CNT_W-1:0]   top_reg;
    logic [wsd_pkg::CNT_W-1:0]   top_next;
    logic [wsd_pkg::STAT_W-1:0]  status_reg;
    logic [wsd_pkg::STAT_W-1:0]  status_next;
    logic                        sel_reg;
    logic                        sel_next;
    logic [wsd_pkg::VALUE_W-1:0] rd_data_reg;

    logic [wsd_pkg::CNT_W-1:0]   held;
    logic [wsd_pkg::CNT_W-1:0]   bottom_dec;
    logic                        is_empty;
    logic                        is_full;
    logic                        wr_en;
    logic                        rd_en;
    logic [wsd_pkg::ADDR_W-1:0]  rd_addr;

    assign held       = bottom_reg - top_reg;
    assign bottom_dec = bottom_reg - wsd_pkg::CNT_W'(1);
    assign is_empty   = (held == '0);
    assign is_full    = (held == wsd_pkg::CNT_W'(wsd_pkg::DEPTH));

    always_comb
    begin
        bottom_next = bottom_reg;
        top_next    = top_reg;
        status_next = wsd_pkg::STAT_OK;
        sel_next    = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = top_reg[wsd_pkg::ADDR_W-1:0];
        case (mode)
            wsd_pkg::MODE_PUSH:
            begin
                if (is_full)
                begin
                    status_next = wsd_pkg::STAT_FULL;
                end
                else
                begin
                    wr_en       = cmd.load;
                    bottom_next = bottom_reg + wsd_pkg::CNT_W'(1);
                end
            end
            wsd_pkg::MODE_TAKE:
            begin
                rd_addr = bottom_dec[wsd_pkg::ADDR_W-1:0];
                if (is_empty)
                begin
                    status_next = wsd_pkg::STAT_EMPTY;
                end
                else
                begin
                    rd_en    = cmd.load;
                    sel_next = 1'b1;
                    // last element: top moves, bottom stays
                    if (held == wsd_pkg::CNT_W'(1))
                    begin
                        top_next = top_reg + wsd_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        bottom_next = bottom_dec;
                    end
                end
            end
            wsd_pkg::MODE_STEAL:
            begin
                if (is_empty)
                begin
                    status_next = wsd_pkg::STAT_EMPTY;
                end
                else
                begin
                    rd_en    = cmd.load;
                    sel_next = 1'b1;
                    top_next = top_reg + wsd_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                // unused code: no operation
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bottom_reg <= '0;
            top_reg    <= '0;
        end
        else if (cmd.load)
        begin
            bottom_reg <= bottom_next;
            top_reg    <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg <= status_next;
            sel_reg    <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[bottom_reg[wsd_pkg::ADDR_W-1:0]] <= value_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    assign status    = status_reg;
    assign value_out = sel_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> src/wsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module wsd_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [wsd_pkg::MODE_W-1:0]    mode,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [wsd_pkg::STAT_W-1:0]    status,
    input  wire logic [wsd_pkg::VALUE_W-1:0]   value_out
);

    logic in_xfer;
    logic out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // every operation yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> out_valid)
        else $error("no result after operation transfer");

    // a pending result blocks further operations
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_xfer) |-> !in_ready)
        else $error("operation accepted while result still pending");

    // push never returns a value
    a_push_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && mode == wsd_pkg::MODE_PUSH) |=> (value_out == '0))
        else $error("push returned nonzero value");

    // only a push can report full
    a_full_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && mode != wsd_pkg::MODE_PUSH) |=> (status != wsd_pkg::STAT_FULL))
        else $error("full status on take or steal");

    // result holds until transferred
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(value_out)))
        else $error("result changed before transfer");

endmodule

bind work_stealing_deque_core wsd_checker u_wsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .value_out (value_out)
);

`default_nettype wire
